/* rtl/ddq_pkg.sv */
package ddq_pkg;

  localparam int WORD_W = 32;

  // word reported for an empty end or a failed pop
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  // operation strobes broadcast to every cell
  typedef struct packed {
    logic add_head;
    logic add_tail;
    logic take_head;
    logic take_tail;
  } cell_ctl_t;

endpackage

/* rtl/ddq_cell.sv */
module ddq_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ddq_pkg::cell_ctl_t           ctl,
  input  logic [ddq_pkg::WORD_W-1:0]   push_word,
  input  logic [ddq_pkg::WORD_W-1:0]   left_word,
  input  logic                         left_vld,
  input  logic [ddq_pkg::WORD_W-1:0]   right_word,
  input  logic                         right_vld,
  output logic [ddq_pkg::WORD_W-1:0]   word,
  output logic                         vld,
  output logic [ddq_pkg::WORD_W-1:0]   tail_word
);

  logic [ddq_pkg::WORD_W-1:0] word_r, word_nxt;
  logic                       vld_r, vld_nxt;

  // shift toward the back, fill the first free slot, shift toward the front, or drop the tail
  always_comb begin
    word_nxt = word_r;
    vld_nxt  = vld_r;
    if (ctl.add_head) begin
      word_nxt = left_word;
      vld_nxt  = left_vld;
    end else if (ctl.add_tail) begin
      if (!vld_r && left_vld) begin
        word_nxt = push_word;
        vld_nxt  = 1'b1;
      end
    end else if (ctl.take_head) begin
      word_nxt = right_word;
      vld_nxt  = right_vld;
    end else if (ctl.take_tail) begin
      if (vld_r && !right_vld) begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word      = word_r;
  assign vld       = vld_r;
  // only the last occupied cell shows its word to the tail tree
  assign tail_word = (vld_r && !right_vld) ? word_r : '0;

endmodule

/* rtl/ddq_tail_tree.sv */
module ddq_tail_tree #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic [ddq_pkg::WORD_W-1:0] leaf [CAPACITY],
  output logic [ddq_pkg::WORD_W-1:0] root
);

  localparam int LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEAVES = 1 << LEVELS;

  logic [ddq_pkg::WORD_W-1:0] node_r [LEAVES-1];
  logic [ddq_pkg::WORD_W-1:0] all_w  [2*LEAVES-1];

  // heap layout: registered inner nodes first, then the padded leaves
  always_comb begin
    for (int k = 0; k < LEAVES - 1; k++) begin
      all_w[k] = node_r[k];
    end
    for (int j = 0; j < LEAVES; j++) begin
      all_w[LEAVES-1+j] = (j < CAPACITY) ? leaf[j] : '0;
    end
  end

  // one tree level per cycle; at most one leaf is nonzero
  always_ff @(posedge clk) begin
    for (int k = 0; k < LEAVES - 1; k++) begin
      node_r[k] <= all_w[2*k+1] | all_w[2*k+2];
    end
  end

  assign root = node_r[0];

endmodule

/* rtl/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit words, CAPACITY entries deep, held in a
// row of cells with the front word always in the first cell. Each accepted command
// (push front, push back, pop front, pop back, query) yields one result with the popped
// word, a failure flag, the front and back words, the entry count and an empty flag.
// A push onto a full queue is dropped and flagged; a pop of an empty queue returns -1
// and is flagged. A command is taken only while the block is idle; its result is registered
// once the registered tree that finds the back word, one level a cycle, has settled, and no
// new command is taken until that result has moved into the output register.
// A finished result may wait on out_ready while the next command is already accepted.
module double_ended_queue #(
  parameter int CAPACITY = 64,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_command,
  input  logic signed [31:0]  in_push_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_popped_value,
  output logic                out_op_failed,
  output logic signed [31:0]  out_front_value,
  output logic signed [31:0]  out_back_value,
  output logic [CW-1:0]       out_count_after,
  output logic                out_is_empty
);

  localparam int LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW     = $clog2(LEVELS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  logic [LW-1:0]              lvl_cnt_r, lvl_cnt_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [ddq_pkg::WORD_W-1:0] popped_r, popped_nxt;
  logic                       failed_r, failed_nxt;

  logic                       out_valid_r;
  logic [ddq_pkg::WORD_W-1:0] out_popped_r, out_front_r, out_back_r;
  logic                       out_failed_r, out_empty_r;
  logic [CW-1:0]              out_count_r;

  ddq_pkg::cell_ctl_t         ctl;
  logic                       in_xfer, full, empty, scan_done, out_free;
  logic [ddq_pkg::WORD_W-1:0] cell_word [CAPACITY];
  logic [ddq_pkg::WORD_W-1:0] cell_tail [CAPACITY];
  logic [CAPACITY-1:0]        cell_vld;
  logic [ddq_pkg::WORD_W-1:0] tail_root;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign scan_done = (state_r == ST_SCAN) && (lvl_cnt_r == LW'(LEVELS));
  assign out_free  = !out_valid_r || out_ready;

  // command decode into cell strobes, counter update, popped word and failure flag
  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    popped_nxt = popped_r;
    failed_nxt = failed_r;
    if (in_xfer) begin
      popped_nxt = '0;
      failed_nxt = 1'b0;
      case (in_command)
        ddq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            failed_nxt = 1'b1;
          end else begin
            ctl.add_head = 1'b1;
            count_nxt    = count_r + CW'(1);
          end
        end
        ddq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            failed_nxt = 1'b1;
          end else begin
            ctl.add_tail = 1'b1;
            count_nxt    = count_r + CW'(1);
          end
        end
        ddq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            popped_nxt = ddq_pkg::EMPTY_WORD;
            failed_nxt = 1'b1;
          end else begin
            ctl.take_head = 1'b1;
            popped_nxt    = cell_word[0];
            count_nxt     = count_r - CW'(1);
          end
        end
        ddq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            popped_nxt = ddq_pkg::EMPTY_WORD;
            failed_nxt = 1'b1;
          end else begin
            ctl.take_tail = 1'b1;
            popped_nxt    = tail_root;
            count_nxt     = count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer: wait for the tail tree to settle, then hand over the result
  always_comb begin
    state_nxt   = state_r;
    lvl_cnt_nxt = lvl_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt   = ST_SCAN;
          lvl_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (lvl_cnt_r != LW'(LEVELS)) begin
          lvl_cnt_nxt = lvl_cnt_r + LW'(1);
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lvl_cnt_r <= '0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      lvl_cnt_r <= lvl_cnt_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    failed_r <= failed_nxt;
  end

  // row of cells, front at cell zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ddq_pkg::WORD_W-1:0] lw, rw;
    logic                       lv, rv;
    if (i == 0) begin : g_first
      assign lw = in_push_value;
      assign lv = 1'b1;
    end else begin : g_mid_l
      assign lw = cell_word[i-1];
      assign lv = cell_vld[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rw = '0;
      assign rv = 1'b0;
    end else begin : g_mid_r
      assign rw = cell_word[i+1];
      assign rv = cell_vld[i+1];
    end
    ddq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_word  (in_push_value),
      .left_word  (lw),
      .left_vld   (lv),
      .right_word (rw),
      .right_vld  (rv),
      .word       (cell_word[i]),
      .vld        (cell_vld[i]),
      .tail_word  (cell_tail[i])
    );
  end

  ddq_tail_tree #(
    .CAPACITY (CAPACITY)
  ) u_tail_tree (
    .clk  (clk),
    .leaf (cell_tail),
    .root (tail_root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (scan_done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done && out_free) begin
      out_popped_r <= popped_r;
      out_failed_r <= failed_r;
      out_front_r  <= cell_vld[0] ? cell_word[0] : ddq_pkg::EMPTY_WORD;
      out_back_r   <= cell_vld[0] ? tail_root : ddq_pkg::EMPTY_WORD;
      out_count_r  <= count_r;
      out_empty_r  <= empty;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_op_failed    = out_failed_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_count_after  = out_count_r;
  assign out_is_empty     = out_empty_r;

`ifndef ASSERT_OFF
  // occupied cells always match the entry counter
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(count_r))
    else $error("cell occupancy differs from entry count");

  // a transfer closes the input until the result is handed over
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input open right after a transfer");

  // an empty result reports both ends as -1
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_front_value == -32'sd1) && (out_back_value == -32'sd1))
    else $error("empty result with a stored end word");
`endif

endmodule
